// ===== design/assert_macros.svh =====
// Assertion macros shared by the sky sphere rotation RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, quiet while reset is asserted.
`define SSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds.
`define SSR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `SSR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== design/ssr_pkg.sv =====
// Package for the sky sphere rotation block: widths, types, register codes,
// elaboration-time CORDIC tables and small arithmetic helpers. No dependencies.
package ssr_pkg;

  localparam int ANGLE_FRAC_BITS   = 28;
  localparam int CORDIC_STAGES_DEF = 30;
  localparam int MAX_STAGES        = 40;
  localparam int ZF                = 40;
  localparam int VF                = 30;
  localparam int ASH               = ZF - ANGLE_FRAC_BITS;

  localparam int Z_W         = 45;
  localparam int XY_W        = 36;
  localparam int SQ_W        = 62;
  localparam int SQRT_CELLS  = 31;
  localparam int ALPHA_IN_W  = 32;
  localparam int DELTA_W     = 30;
  localparam int ALPHA_OUT_W = 31;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_REF_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_DELTA = 1'b1;

  typedef logic signed [Z_W-1:0]  ang_t;
  typedef logic signed [XY_W-1:0] vec_t;
  typedef logic [SQ_W-1:0]        sq_t;
  typedef logic signed [2*XY_W-1:0] prod_t;
  typedef longint unsigned        u64_t;

  localparam longint unsigned ONE62      = 64'd1 << 62;
  localparam longint unsigned ONE62_DIV9 = ONE62 / 9;

  // unsigned quotient by shift and subtract, used only for the constant tables
  function automatic longint unsigned udiv_c(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    int i;
    q   = 0;
    rem = 0;
    for (i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((n >> i) & 64'd1);
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned isqrt_c(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    longint unsigned m;
    r = 0;
    b = 64'd1 << 62;
    m = n;
    while (b > m) b = b >> 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m = m - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(2^-i) in Q62 by its Taylor series, each term truncated; for i = 0 only the first term
  function automatic longint atan_recip_q62(int i);
    longint sum;
    longint unsigned t;
    int k;
    int e;
    bit done;
    sum  = 0;
    done = 1'b0;
    for (k = 0; k < 64; k++) begin
      if (!done) begin
        e = i * (2 * k + 1);
        if (e > 62) begin
          done = 1'b1;
        end else begin
          t = udiv_c(64'd1 << (62 - e), u64_t'(2 * k + 1));
          if (k[0]) sum = sum - longint'(t);
          else      sum = sum + longint'(t);
          if (i == 0) done = 1'b1;
        end
      end
    end
    return sum;
  endfunction

  // atan(1) in Q62 as atan(1/2) + atan(1/3)
  function automatic longint quarter_q62();
    longint third;
    longint unsigned p;
    longint unsigned t;
    int k;
    bit done;
    third = 0;
    p     = 3;
    done  = 1'b0;
    for (k = 0; k < 40; k++) begin
      if (!done) begin
        t = udiv_c(udiv_c(ONE62, p), u64_t'(2 * k + 1));
        if (k[0]) third = third - longint'(t);
        else      third = third + longint'(t);
        if (p > ONE62_DIV9) done = 1'b1;
        else                p = p * 9;
      end
    end
    return atan_recip_q62(1) + third;
  endfunction

  function automatic longint pi_q40_f();
    return (quarter_q62() + (longint'(1) << 19)) >>> 20;
  endfunction

  function automatic longint atan_q40(int i);
    if (i == 0) return (quarter_q62() + (longint'(1) << 21)) >>> 22;
    return (atan_recip_q62(i) + (longint'(1) << 21)) >>> 22;
  endfunction

  function automatic longint gain_inv_f(int stages);
    longint unsigned prod;
    longint unsigned add;
    longint unsigned g;
    int i;
    prod = 64'd1 << VF;
    for (i = 0; i < MAX_STAGES; i++) begin
      if (i < stages) begin
        add  = (2 * i <= 60) ? (64'd1 << (60 - 2 * i)) : 64'd0;
        g    = isqrt_c((64'd1 << 60) + add);
        prod = (prod * g) >> VF;
      end
    end
    return longint'(udiv_c((64'd1 << 60) + (prod >> 1), prod));
  endfunction

  localparam ang_t PI_A     = ang_t'(pi_q40_f());
  localparam ang_t TWO_PI_A = PI_A + PI_A;
  localparam ang_t HALF_PI  = PI_A >>> 1;
  localparam ang_t RND_HALF = ang_t'(1) <<< (ASH - 1);
  localparam ang_t B_ALPHA  = (PI_A + RND_HALF) >>> ASH;
  localparam ang_t B_DELTA  = (HALF_PI + RND_HALF) >>> ASH;

  // truncating remainder by 2*pi; the quotient never exceeds one here
  function automatic ang_t mod_two_pi(ang_t z);
    if (!z[Z_W-1] && z >= TWO_PI_A) return z - TWO_PI_A;
    if (z[Z_W-1] && z <= -TWO_PI_A) return z + TWO_PI_A;
    return z;
  endfunction

  function automatic ang_t wrap_pi(ang_t z);
    if (z > PI_A) return z - TWO_PI_A;
    if (z <= -PI_A) return z + TWO_PI_A;
    return z;
  endfunction

  function automatic vec_t qmul(vec_t a, vec_t b);
    prod_t p;
    p = a * b;
    return vec_t'(p >>> VF);
  endfunction

  // round half up to the output grid, then clamp to +-bound
  function automatic ang_t to_field(ang_t z, ang_t bound);
    ang_t v;
    v = (z + RND_HALF) >>> ASH;
    if (v > bound) v = bound;
    if (v < -bound) v = -bound;
    return v;
  endfunction

endpackage

// ===== design/ssr_channels.sv =====
// Handshake channels of the sky sphere rotation block: input point and result.
// Depends on ssr_pkg for the field widths.
interface ssr_in_if import ssr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [ALPHA_IN_W-1:0] alpha_in;
  logic signed [DELTA_W-1:0]    delta_in;

  modport source (output valid, func, alpha_in, delta_in, input ready);
  modport sink   (input valid, func, alpha_in, delta_in, output ready);
endinterface

interface ssr_out_if import ssr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [ALPHA_OUT_W-1:0] alpha_out;
  logic signed [DELTA_W-1:0]     delta_out;

  modport source (output valid, alpha_out, delta_out, input ready);
  modport sink   (input valid, alpha_out, delta_out, output ready);
endinterface

// ===== design/ssr_rot_cell.sv =====
// One CORDIC rotation-mode cell: a fixed shift and arctangent per stage.
// Depends on ssr_pkg.
module ssr_rot_cell import ssr_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic en,
  input  vec_t x_i,
  input  vec_t y_i,
  input  ang_t z_i,
  output vec_t x_o,
  output vec_t y_o,
  output ang_t z_o
);
  localparam ang_t ATAN = ang_t'(atan_q40(STAGE));

  vec_t x_r, y_r, x_nxt, y_nxt;
  ang_t z_r, z_nxt;
  vec_t dx, dy;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!z_i[Z_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

// ===== design/ssr_vec_cell.sv =====
// One CORDIC vectoring-mode cell: drive y toward zero, collect the angle.
// Depends on ssr_pkg.
module ssr_vec_cell import ssr_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic en,
  input  vec_t x_i,
  input  vec_t y_i,
  input  ang_t z_i,
  output vec_t x_o,
  output vec_t y_o,
  output ang_t z_o
);
  localparam ang_t ATAN = ang_t'(atan_q40(STAGE));

  vec_t x_r, y_r, x_nxt, y_nxt;
  ang_t z_r, z_nxt;
  vec_t dx, dy;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!y_i[XY_W-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

// ===== design/ssr_sqrt_cell.sv =====
// One digit cell of the restoring integer square root (one result bit).
// Depends on ssr_pkg.
module ssr_sqrt_cell import ssr_pkg::*; #(
  parameter int BIT_EXP = 0
) (
  input  logic clk,
  input  logic en,
  input  sq_t  n_i,
  input  sq_t  r_i,
  output sq_t  n_o,
  output sq_t  r_o
);
  localparam sq_t BITV = sq_t'(1) << BIT_EXP;

  sq_t n_r, r_r, n_nxt, r_nxt, trial;

  always_comb begin
    trial = r_i + BITV;
    if (n_i >= trial) begin
      n_nxt = n_i - trial;
      r_nxt = (r_i >> 1) + BITV;
    end else begin
      n_nxt = n_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      r_r <= r_nxt;
    end
  end

  assign n_o = n_r;
  assign r_o = r_r;
endmodule

// ===== design/sky_sphere_rotation.sv =====
// Top level of the sky sphere rotation block: config registers, cell chains,
// matrix stages and result buffer. Depends on ssr_pkg, ssr_channels, the cells and assert_macros.
`include "assert_macros.svh"

// Rotates a sky point (right ascension, declination, 2^-28 rad) by the
// rotation that carries the configured reference point to declination -pi/2
// (func 0) or by its inverse (func 1). The block is a fully pipelined chain:
// angle reduction, four parallel CORDIC sine/cosine chains, three multiply
// stages for the 3x3 matrix, a 31-cell square-root chain and two CORDIC
// vectoring chains. It takes one item every cycle while the result buffer has
// room; each item's result is offered on out_ch once it has been written into
// the result buffer, and the depth is set by the cell chains. A two-entry
// result buffer lets the pipeline keep accepting while one result waits for
// out_ch.ready; in_ch.ready drops only when both entries are full, and the
// whole pipeline then holds. Write ref_alpha and ref_delta only while no item
// is in flight.
module sky_sphere_rotation import ssr_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ssr_in_if.sink               in_ch,
  ssr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);
  localparam int   LAT        = 41 + 2 * CORDIC_STAGES;
  localparam vec_t GAIN_INV_V = vec_t'(gain_inv_f(CORDIC_STAGES));
  localparam sq_t  ONE60      = sq_t'(1) << 60;
  localparam vec_t ONE_V      = vec_t'(1) <<< VF;

  typedef struct packed {
    logic [3:0] neg;
    logic       func;
  } rot_side_t;

  typedef struct packed {
    vec_t zc;
    vec_t v0;
    vec_t v1;
    logic zero;
  } sqrt_side_t;

  typedef struct packed {
    logic signed [ALPHA_OUT_W-1:0] alpha;
    logic signed [DELTA_W-1:0]     delta;
  } res_t;

  // configuration registers
  logic signed [ALPHA_IN_W-1:0] ref_alpha_r;
  logic signed [DELTA_W-1:0]    ref_delta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_alpha_r <= '0;
      ref_delta_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_ALPHA: ref_alpha_r <= cfg_wdata[ALPHA_IN_W-1:0];
        REG_REF_DELTA: ref_delta_r <= cfg_wdata[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: the whole chain moves while the result buffer has room
  logic [1:0] cnt_r;
  logic       adv, accept, push, pop;
  logic [LAT-1:0] valid_r;

  assign adv         = (cnt_r != 2'd2);
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid & adv;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (adv) valid_r <= {valid_r[LAT-2:0], accept};
  end

  // stage A: scale to Q40 and take out whole turns
  // angle order: ref alpha, ref delta, point alpha, point delta
  ang_t a_in [4];
  ang_t a_r [4];
  ang_t b_r [4];
  ang_t c_z_r [4];
  logic [3:0] c_neg_r;
  logic a_func_r, b_func_r, c_func_r;

  always_comb begin
    a_in[0] = ang_t'(ref_alpha_r) <<< ASH;
    a_in[1] = ang_t'(ref_delta_r) <<< ASH;
    a_in[2] = ang_t'(in_ch.alpha_in) <<< ASH;
    a_in[3] = ang_t'(in_ch.delta_in) <<< ASH;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) a_r[k] <= mod_two_pi(a_in[k]);
      a_func_r <= in_ch.func;
      for (int k = 0; k < 4; k++) b_r[k] <= wrap_pi(a_r[k]);
      b_func_r <= a_func_r;
      // fold beyond +-pi/2 by a half turn, negate sine and cosine later
      for (int k = 0; k < 4; k++) begin
        if (b_r[k] > HALF_PI) begin
          c_z_r[k]   <= b_r[k] - PI_A;
          c_neg_r[k] <= 1'b1;
        end else if (b_r[k] < -HALF_PI) begin
          c_z_r[k]   <= b_r[k] + PI_A;
          c_neg_r[k] <= 1'b1;
        end else begin
          c_z_r[k]   <= b_r[k];
          c_neg_r[k] <= 1'b0;
        end
      end
      c_func_r <= b_func_r;
    end
  end

  // four sine/cosine chains
  vec_t rot_x [4][CORDIC_STAGES+1];
  vec_t rot_y [4][CORDIC_STAGES+1];
  ang_t rot_z [4][CORDIC_STAGES+1];
  rot_side_t rs_r [CORDIC_STAGES];

  for (genvar gk = 0; gk < 4; gk++) begin : g_sc
    assign rot_x[gk][0] = GAIN_INV_V;
    assign rot_y[gk][0] = '0;
    assign rot_z[gk][0] = c_z_r[gk];
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cell
      ssr_rot_cell #(.STAGE(gi)) u_cell (
        .clk (clk),
        .en  (adv),
        .x_i (rot_x[gk][gi]),
        .y_i (rot_y[gk][gi]),
        .z_i (rot_z[gk][gi]),
        .x_o (rot_x[gk][gi+1]),
        .y_o (rot_y[gk][gi+1]),
        .z_o (rot_z[gk][gi+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_r[0] <= '{neg: c_neg_r, func: c_func_r};
      for (int i = 1; i < CORDIC_STAGES; i++) rs_r[i] <= rs_r[i-1];
    end
  end

  // apply the half-turn sign, then the matrix stages
  vec_t cs_r [4];
  vec_t sn_r [4];
  logic sc_func_r;
  rot_side_t rs_last;
  assign rs_last = rs_r[CORDIC_STAGES-1];

  vec_t vi_r [3];
  vec_t sdca_r, sdsa_r, cdca_r, cdsa_r, ca_r, sa_r, cd_r, sd_r;
  logic m1_func_r;
  vec_t mat [3][3];
  prod_t prod_r [3][3];
  vec_t v_r [3];

  always_comb begin
    mat[0][0] = -sdca_r; mat[0][1] = -sdsa_r; mat[0][2] = cd_r;
    mat[1][0] = -sa_r;   mat[1][1] = ca_r;    mat[1][2] = '0;
    mat[2][0] = -cdca_r; mat[2][1] = -cdsa_r; mat[2][2] = -sd_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        cs_r[k] <= rs_last.neg[k] ? -rot_x[k][CORDIC_STAGES] : rot_x[k][CORDIC_STAGES];
        sn_r[k] <= rs_last.neg[k] ? -rot_y[k][CORDIC_STAGES] : rot_y[k][CORDIC_STAGES];
      end
      sc_func_r <= rs_last.func;
      // unit vector of the point and the reference products
      vi_r[0] <= qmul(cs_r[3], cs_r[2]);
      vi_r[1] <= qmul(cs_r[3], sn_r[2]);
      vi_r[2] <= sn_r[3];
      sdca_r  <= qmul(sn_r[1], cs_r[0]);
      sdsa_r  <= qmul(sn_r[1], sn_r[0]);
      cdca_r  <= qmul(cs_r[1], cs_r[0]);
      cdsa_r  <= qmul(cs_r[1], sn_r[0]);
      ca_r    <= cs_r[0];
      sa_r    <= sn_r[0];
      cd_r    <= cs_r[1];
      sd_r    <= sn_r[1];
      m1_func_r <= sc_func_r;
      // inverse mode uses the transposed matrix
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          prod_r[r][c] <= (m1_func_r ? mat[c][r] : mat[r][c]) * vi_r[c];
      for (int r = 0; r < 3; r++)
        v_r[r] <= vec_t'(((prod_r[r][0] + prod_r[r][1]) + prod_r[r][2]) >>> VF);
    end
  end

  // saturate the third component and form 1 - z^2
  vec_t s1_zc_r, s1_v0_r, s1_v1_r;
  logic s1_zero_r;
  prod_t zsq;
  sq_t  s2_n_r;
  sqrt_side_t s2_side_r;

  assign zsq = s1_zc_r * s1_zc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v_r[2] > ONE_V)       s1_zc_r <= ONE_V;
      else if (v_r[2] < -ONE_V) s1_zc_r <= -ONE_V;
      else                      s1_zc_r <= v_r[2];
      s1_v0_r   <= v_r[0];
      s1_v1_r   <= v_r[1];
      s1_zero_r <= (v_r[0] == '0) && (v_r[1] == '0);
      s2_n_r    <= ONE60 - sq_t'(zsq[SQ_W-1:0]);
      s2_side_r <= '{zc: s1_zc_r, v0: s1_v0_r, v1: s1_v1_r, zero: s1_zero_r};
    end
  end

  // square root chain, one result bit per cell
  sq_t sq_n [SQRT_CELLS+1];
  sq_t sq_r [SQRT_CELLS+1];
  sqrt_side_t qs_r [SQRT_CELLS];

  assign sq_n[0] = s2_n_r;
  assign sq_r[0] = '0;

  for (genvar gj = 0; gj < SQRT_CELLS; gj++) begin : g_sqrt
    ssr_sqrt_cell #(.BIT_EXP(60 - 2 * gj)) u_cell (
      .clk (clk),
      .en  (adv),
      .n_i (sq_n[gj]),
      .r_i (sq_r[gj]),
      .n_o (sq_n[gj+1]),
      .r_o (sq_r[gj+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qs_r[0] <= s2_side_r;
      for (int i = 1; i < SQRT_CELLS; i++) qs_r[i] <= qs_r[i-1];
    end
  end

  // vectoring start: move a left-half plane vector by a half turn
  sqrt_side_t qs_last;
  vec_t va_x_r, va_y_r, vb_x_r, vb_y_r;
  ang_t va_z_r;
  logic v0_zero_r;
  assign qs_last = qs_r[SQRT_CELLS-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (qs_last.v0[XY_W-1]) begin
        va_x_r <= -qs_last.v0;
        va_y_r <= -qs_last.v1;
        va_z_r <= qs_last.v1[XY_W-1] ? -PI_A : PI_A;
      end else begin
        va_x_r <= qs_last.v0;
        va_y_r <= qs_last.v1;
        va_z_r <= '0;
      end
      vb_x_r    <= vec_t'(sq_r[SQRT_CELLS][XY_W-1:0]);
      vb_y_r    <= qs_last.zc;
      v0_zero_r <= qs_last.zero;
    end
  end

  // two vectoring chains: plane angle and arcsine
  vec_t vax [CORDIC_STAGES+1];
  vec_t vay [CORDIC_STAGES+1];
  ang_t vaz [CORDIC_STAGES+1];
  vec_t vbx [CORDIC_STAGES+1];
  vec_t vby [CORDIC_STAGES+1];
  ang_t vbz [CORDIC_STAGES+1];
  logic vz_r [CORDIC_STAGES];

  assign vax[0] = va_x_r;
  assign vay[0] = va_y_r;
  assign vaz[0] = va_z_r;
  assign vbx[0] = vb_x_r;
  assign vby[0] = vb_y_r;
  assign vbz[0] = '0;

  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec
    ssr_vec_cell #(.STAGE(gi)) u_cell_a (
      .clk (clk),
      .en  (adv),
      .x_i (vax[gi]),
      .y_i (vay[gi]),
      .z_i (vaz[gi]),
      .x_o (vax[gi+1]),
      .y_o (vay[gi+1]),
      .z_o (vaz[gi+1])
    );
    ssr_vec_cell #(.STAGE(gi)) u_cell_b (
      .clk (clk),
      .en  (adv),
      .x_i (vbx[gi]),
      .y_i (vby[gi]),
      .z_i (vbz[gi]),
      .x_o (vbx[gi+1]),
      .y_o (vby[gi+1]),
      .z_o (vbz[gi+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vz_r[0] <= v0_zero_r;
      for (int i = 1; i < CORDIC_STAGES; i++) vz_r[i] <= vz_r[i-1];
    end
  end

  // round to the output grid; a zero plane vector gives alpha 0
  ang_t a_fld, d_fld;
  res_t res;

  always_comb begin
    a_fld = vz_r[CORDIC_STAGES-1] ? '0 : to_field(vaz[CORDIC_STAGES], B_ALPHA);
    d_fld = to_field(vbz[CORDIC_STAGES], B_DELTA);
    res.alpha = a_fld[ALPHA_OUT_W-1:0];
    res.delta = d_fld[DELTA_W-1:0];
  end

  // two-entry result buffer
  res_t buf_r [2];
  logic wptr_r, rptr_r;

  assign push = valid_r[LAT-1] & adv;
  assign pop  = out_ch.valid & out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wptr_r] <= res;
  end

  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.alpha_out = buf_r[rptr_r].alpha;
  assign out_ch.delta_out = buf_r[rptr_r].delta;

  `SSR_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= 2'd2, "result count out of range")
  `SSR_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && (cnt_r == 2'd2), "push into full buffer")
  `SSR_ASSERT(a_ready_room, clk, rst_n, !in_ch.ready |-> (cnt_r == 2'd2), "ready low, room left")
  `SSR_ASSERT(a_delta_hi, clk, rst_n, out_ch.valid |-> out_ch.delta_out <= B_DELTA, "delta high")
  `SSR_ASSERT(a_delta_lo, clk, rst_n, out_ch.valid |-> out_ch.delta_out >= -B_DELTA, "delta low")
endmodule
